// ===== rtl/sbq_pkg.sv =====
package sbq_pkg;

  localparam int BUFFER_BYTES_DEF = 2048;
  localparam int MAX_QUEUES_DEF = 511;

  // Descriptor word: pos[31:21] len[20:10] next[9:1] used[0].
  localparam int POS_W = 11;
  localparam int LEN_W = 11;
  localparam int SLOT_W = 9;
  localparam int CNT_W = 12;
  localparam int DESC_W = 32;
  localparam int PROD_W = 21;
  localparam int LIVE_W = 10;

  typedef logic [DESC_W-1:0] desc_t;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_ENQUEUE = 2'd2,
    CMD_DEQUEUE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOMEM    = 2'd2,
    ST_NOHANDLE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RET_PASS_UP,
    RET_PASS_DOWN,
    RET_TAIL
  } ret_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_DISPATCH,
    S_CR_NEW_CK,
    S_CR_NEW_WR,
    S_CR_SCAN_RD,
    S_CR_SCAN_CK,
    S_CR_NX_RD,
    S_CR_NX_CK,
    S_CR_PREV_CK,
    S_CR_LIM_CK,
    S_CR_WR,
    S_CR_WR2,
    S_VAL_CK,
    S_DS_SCAN_RD,
    S_DS_SCAN_CK,
    S_EQ_NX_CK,
    S_SH_NN_CK,
    S_SH_EVAL,
    S_EQ_TAIL_RD,
    S_EQ_TAIL_CK,
    S_DQ_BYTE,
    S_MV_START,
    S_MV_RD,
    S_MV_WR,
    S_MV_FIN,
    S_MV_RET,
    S_RS_START,
    S_RS_P1_RD,
    S_RS_P1_CK,
    S_RS_DIVGO,
    S_RS_DIVW,
    S_RS_P2_RD,
    S_RS_P2_CK,
    S_RS_END,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [SLOT_W-1:0] qid;
    logic [7:0]       din;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] new_queue;
    logic [7:0]        data_out;
    status_t           status;
  } resp_t;

  function automatic logic [POS_W-1:0] w_pos(input desc_t w);
    return w[31:21];
  endfunction

  function automatic logic [LEN_W-1:0] w_len(input desc_t w);
    return w[20:10];
  endfunction

  function automatic logic [SLOT_W-1:0] w_nxt(input desc_t w);
    return w[9:1];
  endfunction

  function automatic logic w_used(input desc_t w);
    return w[0];
  endfunction

  function automatic desc_t w_put(input logic [POS_W-1:0] p, input logic [LEN_W-1:0] l,
                                  input logic [SLOT_W-1:0] n);
    return {p, l, n, 1'b1};
  endfunction

  function automatic desc_t w_link(input desc_t w, input logic [SLOT_W-1:0] n);
    return {w[31:10], n, w[0]};
  endfunction

endpackage

// ===== rtl/sbq_in_if.sv =====
interface sbq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [8:0] queue_id;
  logic [7:0] data_in;

  modport source(output valid, command, queue_id, data_in, input ready);
  modport sink(input valid, command, queue_id, data_in, output ready);
endinterface

// ===== rtl/sbq_out_if.sv =====
interface sbq_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] new_queue;
  logic [7:0] data_out;
  logic [1:0] status;

  modport source(output valid, new_queue, data_out, status, input ready);
  modport sink(input valid, new_queue, data_out, status, output ready);
endinterface

// ===== rtl/sbq_div.sv =====
module sbq_div #(
  parameter int DW = 21,
  parameter int VW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem, quot[DW-1]};
    diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[VW]) begin
        rem <= diff[VW-1:0];
        quot <= {quot[DW-2:0], 1'b1};
      end else begin
        rem <= trial[VW-1:0];
        quot <= {quot[DW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/sbq_ctrl.sv =====
module sbq_ctrl #(
  parameter int BUFFER_BYTES = 2048,
  parameter int MAX_QUEUES = 511
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sbq_pkg::req_t req,
  input  logic          res_ok,
  output logic          idle,
  output logic          emit,
  output sbq_pkg::resp_t resp,
  output logic          div_start,
  output logic [sbq_pkg::PROD_W-1:0] div_dividend,
  output logic [sbq_pkg::LIVE_W-1:0] div_divisor,
  input  logic          div_done,
  input  logic [sbq_pkg::PROD_W-1:0] div_quot
);
  import sbq_pkg::*;

  localparam int SAW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int BAW = $clog2(BUFFER_BYTES);
  localparam logic [12:0] BUF13 = 13'(BUFFER_BYTES);
  localparam logic [SLOT_W-1:0] MAXQ = SLOT_W'(MAX_QUEUES);

  desc_t           dmem [MAX_QUEUES];
  logic [CNT_W-1:0] tmem [MAX_QUEUES];
  logic [7:0]      bmem [BUFFER_BYTES];

  logic            d_re, d_we, t_re, t_we, b_re, b_we;
  logic [SAW-1:0]  d_raddr, d_waddr, t_addr;
  desc_t           d_wdata, d_rd;
  logic [CNT_W-1:0] t_wdata, t_rd;
  logic [BAW-1:0]  b_raddr, b_waddr;
  logic [7:0]      b_wdata, b_rd;

  state_t st, st_next;
  cmd_t   cmd, cmd_next;
  logic [SLOT_W-1:0] qid, qid_next;
  logic [7:0]  din, din_next;
  logic [SLOT_W-1:0] hs, hs_next;
  logic [LIVE_W-1:0] live, live_next;
  logic [CNT_W-1:0]  region, region_next;
  logic [CNT_W-1:0]  free, free_next;
  logic [SLOT_W-1:0] holes, holes_next;
  logic [9:0]  cur, cur_next;
  logic [9:0]  prv, prv_next;
  desc_t       wq, wq_next;
  desc_t       wn, wn_next;
  logic [CNT_W-1:0]  lim, lim_next;
  logic [SLOT_W-1:0] newq, newq_next;
  logic [7:0]  dout, dout_next;
  status_t     status, status_next;
  ret_t        ret, ret_next;
  logic [SLOT_W-1:0] mv_slot, mv_slot_next;
  desc_t       mv_word, mv_word_next;
  logic [CNT_W-1:0]  mv_to, mv_to_next;
  logic [LEN_W-1:0]  mv_off, mv_off_next;
  logic [LEN_W-1:0]  mv_rem, mv_rem_next;
  logic        mv_up, mv_up_next;
  logic [SLOT_W-1:0] rs_i, rs_i_next;
  logic [CNT_W-1:0]  rs_cum, rs_cum_next;
  logic [PROD_W-1:0] prod, prod_next;

  function automatic logic [SAW-1:0] sa(input logic [9:0] s);
    logic [9:0] t;
    t = s - 10'd1;
    return t[SAW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_waddr] <= d_wdata;
    if (d_re) d_rd <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_addr] <= t_wdata;
    if (t_re) t_rd <= tmem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_waddr] <= b_wdata;
    if (b_re) b_rd <= bmem[b_raddr];
  end

  assign idle = (st == S_IDLE);
  assign resp = '{new_queue: newq, data_out: dout, status: status};
  assign div_dividend = prod;
  assign div_divisor = live;

  always_comb begin
    logic [12:0] s13;
    logic [12:0] e13;
    logic [11:0] q_end;
    logic [11:0] n_end;
    logic [LEN_W-1:0] nl;
    logic [CNT_W-1:0] tgt;
    logic [11:0] mv_from;
    logic [11:0] mv_len;

    st_next = st;
    cmd_next = cmd; qid_next = qid; din_next = din;
    hs_next = hs; live_next = live; region_next = region; free_next = free;
    holes_next = holes; cur_next = cur; prv_next = prv; wq_next = wq; wn_next = wn;
    lim_next = lim; newq_next = newq; dout_next = dout; status_next = status;
    ret_next = ret; mv_slot_next = mv_slot; mv_word_next = mv_word; mv_to_next = mv_to;
    mv_off_next = mv_off; mv_rem_next = mv_rem; mv_up_next = mv_up;
    rs_i_next = rs_i; rs_cum_next = rs_cum; prod_next = prod;
    d_re = 1'b0; d_raddr = '0; d_we = 1'b0; d_waddr = '0; d_wdata = '0;
    t_re = 1'b0; t_we = 1'b0; t_addr = '0; t_wdata = '0;
    b_re = 1'b0; b_raddr = '0; b_we = 1'b0; b_waddr = '0; b_wdata = '0;
    div_start = 1'b0;
    emit = 1'b0;
    q_end = {1'b0, w_pos(wq)} + {1'b0, w_len(wq)};
    n_end = {1'b0, w_pos(wn)} + {1'b0, w_len(wn)};
    mv_from = {1'b0, w_pos(mv_word)};
    mv_len = {1'b0, w_len(mv_word)};
    s13 = '0; e13 = '0; nl = '0; tgt = '0;

    case (st)
      S_IDLE: begin
        if (start) begin
          cmd_next = req.cmd;
          qid_next = req.qid;
          din_next = req.din;
          newq_next = '0;
          dout_next = '0;
          status_next = ST_OK;
          st_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (cmd == CMD_CREATE) begin
          if (holes == '0) begin
            if (hs >= MAXQ) begin
              status_next = ST_NOHANDLE;
              st_next = S_DONE;
            end else if (free < 12'd4) begin
              status_next = ST_NOMEM;
              st_next = S_DONE;
            end else begin
              live_next = live + 1'b1;
              region_next = region - 12'd4;
              free_next = free - 12'd4;
              cur_next = {1'b0, hs} + 10'd1;
              newq_next = hs + 1'b1;
              hs_next = hs + 1'b1;
              if (hs == '0) begin
                d_we = 1'b1;
                d_waddr = sa(10'd1);
                d_wdata = w_put('0, '0, '0);
                st_next = S_DONE;
              end else begin
                d_re = 1'b1;
                d_raddr = sa({1'b0, hs});
                st_next = S_CR_NEW_CK;
              end
            end
          end else begin
            cur_next = 10'd1;
            st_next = S_CR_SCAN_RD;
          end
        end else if (qid == '0 || qid > hs) begin
          if (cmd == CMD_DEQUEUE) status_next = ST_EMPTY;
          st_next = S_DONE;
        end else begin
          d_re = 1'b1;
          d_raddr = sa({1'b0, qid});
          st_next = S_VAL_CK;
        end
      end

      // New slot appended after the previous highest one.
      S_CR_NEW_CK: begin
        wq_next = d_rd;
        d_we = 1'b1;
        d_waddr = sa(cur - 10'd1);
        d_wdata = w_link(d_rd, cur[SLOT_W-1:0]);
        st_next = S_CR_NEW_WR;
      end

      S_CR_NEW_WR: begin
        s13 = {1'b0, q_end} + {1'b0, region};
        d_we = 1'b1;
        d_waddr = sa(cur);
        d_wdata = w_put(s13[11:1], '0, '0);
        st_next = (q_end > region) ? S_RS_START : S_DONE;
      end

      S_CR_SCAN_RD: begin
        if (cur > {1'b0, hs}) begin
          status_next = ST_NOHANDLE;
          st_next = S_DONE;
        end else begin
          d_re = 1'b1;
          d_raddr = sa(cur);
          st_next = S_CR_SCAN_CK;
        end
      end

      S_CR_SCAN_CK: begin
        if (w_used(d_rd)) begin
          cur_next = cur + 10'd1;
          st_next = S_CR_SCAN_RD;
        end else begin
          holes_next = holes - 1'b1;
          live_next = live + 1'b1;
          newq_next = cur[SLOT_W-1:0];
          if (cur == 10'd1) begin
            prv_next = 10'd2;
            st_next = S_CR_NX_RD;
          end else begin
            prv_next = cur - 10'd1;
            d_re = 1'b1;
            d_raddr = sa(cur - 10'd1);
            st_next = S_CR_PREV_CK;
          end
        end
      end

      // Reused first slot: link it to the first live slot above it.
      S_CR_NX_RD: begin
        if (prv > {1'b0, hs}) begin
          d_we = 1'b1;
          d_waddr = sa(10'd1);
          d_wdata = w_put('0, '0, '0);
          st_next = S_DONE;
        end else begin
          d_re = 1'b1;
          d_raddr = sa(prv);
          st_next = S_CR_NX_CK;
        end
      end

      S_CR_NX_CK: begin
        if (w_used(d_rd)) begin
          d_we = 1'b1;
          d_waddr = sa(10'd1);
          d_wdata = w_put('0, '0, prv[SLOT_W-1:0]);
          st_next = S_DONE;
        end else begin
          prv_next = prv + 10'd1;
          st_next = S_CR_NX_RD;
        end
      end

      S_CR_PREV_CK: begin
        wn_next = d_rd;
        if (w_nxt(d_rd) != '0) begin
          d_re = 1'b1;
          d_raddr = sa({1'b0, w_nxt(d_rd)});
          st_next = S_CR_LIM_CK;
        end else begin
          lim_next = region;
          st_next = S_CR_WR;
        end
      end

      S_CR_LIM_CK: begin
        lim_next = {1'b0, w_pos(d_rd)};
        st_next = S_CR_WR;
      end

      S_CR_WR: begin
        d_we = 1'b1;
        d_waddr = sa(prv);
        d_wdata = w_link(wn, cur[SLOT_W-1:0]);
        st_next = S_CR_WR2;
      end

      S_CR_WR2: begin
        s13 = {1'b0, n_end} + {1'b0, lim};
        d_we = 1'b1;
        d_waddr = sa(cur);
        d_wdata = w_put(s13[11:1], '0, w_nxt(wn));
        st_next = S_DONE;
      end

      S_VAL_CK: begin
        wq_next = d_rd;
        if (!w_used(d_rd)) begin
          if (cmd == CMD_DEQUEUE) status_next = ST_EMPTY;
          st_next = S_DONE;
        end else begin
          case (cmd)
            CMD_DESTROY: begin
              holes_next = holes + 1'b1;
              live_next = live - 1'b1;
              free_next = free + {1'b0, w_len(d_rd)};
              d_we = 1'b1;
              d_waddr = sa({1'b0, qid});
              d_wdata = {d_rd[31:1], 1'b0};
              cur_next = {1'b0, qid} - 10'd1;
              st_next = S_DS_SCAN_RD;
            end
            CMD_ENQUEUE: begin
              if (free == '0) begin
                status_next = ST_NOMEM;
                st_next = S_DONE;
              end else begin
                nl = w_len(d_rd) + 1'b1;
                wq_next = w_put(w_pos(d_rd), nl, w_nxt(d_rd));
                d_we = 1'b1;
                d_waddr = sa({1'b0, qid});
                d_wdata = w_put(w_pos(d_rd), nl, w_nxt(d_rd));
                free_next = free - 1'b1;
                n_end = {1'b0, w_pos(d_rd)} + {1'b0, nl};
                if (w_nxt(d_rd) == '0) begin
                  if (n_end > region) begin
                    st_next = S_RS_START;
                  end else begin
                    st_next = S_EQ_TAIL_RD;
                  end
                end else begin
                  d_re = 1'b1;
                  d_raddr = sa({1'b0, w_nxt(d_rd)});
                  st_next = S_EQ_NX_CK;
                end
              end
            end
            CMD_DEQUEUE: begin
              if (w_len(d_rd) == '0) begin
                status_next = ST_EMPTY;
                st_next = S_DONE;
              end else begin
                d_we = 1'b1;
                d_waddr = sa({1'b0, qid});
                d_wdata = w_put(w_pos(d_rd) + 1'b1, w_len(d_rd) - 1'b1, w_nxt(d_rd));
                free_next = free + 1'b1;
                tgt = {1'b0, w_pos(d_rd)};
                if (tgt < BUF13[11:0]) begin
                  b_re = 1'b1;
                  b_raddr = tgt[BAW-1:0];
                  st_next = S_DQ_BYTE;
                end else begin
                  st_next = S_DONE;
                end
              end
            end
            default: st_next = S_DONE;
          endcase
        end
      end

      S_DS_SCAN_RD: begin
        if (cur == '0) begin
          st_next = S_DONE;
        end else begin
          d_re = 1'b1;
          d_raddr = sa(cur);
          st_next = S_DS_SCAN_CK;
        end
      end

      S_DS_SCAN_CK: begin
        if (w_used(d_rd)) begin
          d_we = 1'b1;
          d_waddr = sa(cur);
          d_wdata = w_link(d_rd, w_nxt(wq));
          st_next = S_DONE;
        end else begin
          cur_next = cur - 10'd1;
          st_next = S_DS_SCAN_RD;
        end
      end

      S_EQ_NX_CK: begin
        wn_next = d_rd;
        if (q_end > {1'b0, w_pos(d_rd)}) begin
          if (w_nxt(d_rd) != '0) begin
            d_re = 1'b1;
            d_raddr = sa({1'b0, w_nxt(d_rd)});
            st_next = S_SH_NN_CK;
          end else begin
            lim_next = region;
            st_next = S_SH_EVAL;
          end
        end else begin
          st_next = S_EQ_TAIL_RD;
        end
      end

      S_SH_NN_CK: begin
        lim_next = {1'b0, w_pos(d_rd)};
        st_next = S_SH_EVAL;
      end

      // Push the colliding neighbor up by half of the gap behind it; with no gap, re-spread.
      S_SH_EVAL: begin
        if (n_end < lim) begin
          tgt = lim - n_end + 12'd1;
          mv_to_next = {1'b0, w_pos(wn)} + {1'b0, tgt[11:1]};
          mv_slot_next = w_nxt(wq);
          mv_word_next = wn;
          ret_next = RET_TAIL;
          st_next = S_MV_START;
        end else begin
          st_next = S_RS_START;
        end
      end

      S_EQ_TAIL_RD: begin
        d_re = 1'b1;
        d_raddr = sa({1'b0, qid});
        st_next = S_EQ_TAIL_CK;
      end

      S_EQ_TAIL_CK: begin
        n_end = {1'b0, w_pos(d_rd)} + {1'b0, w_len(d_rd)};
        tgt = n_end - 12'd1;
        if (n_end != '0 && {1'b0, tgt} < BUF13) begin
          b_we = 1'b1;
          b_waddr = tgt[BAW-1:0];
          b_wdata = din;
        end
        st_next = S_DONE;
      end

      S_DQ_BYTE: begin
        dout_next = b_rd;
        st_next = S_DONE;
      end

      S_MV_START: begin
        s13 = {1'b0, mv_from} + {1'b0, mv_len};
        e13 = {1'b0, mv_to} + {1'b0, mv_len};
        if (s13 > BUF13 || e13 > BUF13) begin
          st_next = S_MV_RET;
        end else if (mv_len == '0) begin
          st_next = S_MV_FIN;
        end else begin
          mv_up_next = (mv_to < mv_from);
          mv_rem_next = w_len(mv_word);
          mv_off_next = (mv_to < mv_from) ? '0 : w_len(mv_word) - 1'b1;
          st_next = S_MV_RD;
        end
      end

      S_MV_RD: begin
        tgt = mv_from + {1'b0, mv_off};
        b_re = 1'b1;
        b_raddr = tgt[BAW-1:0];
        st_next = S_MV_WR;
      end

      // Copy direction follows the move so an overlapping run is not clobbered.
      S_MV_WR: begin
        tgt = mv_to + {1'b0, mv_off};
        b_we = 1'b1;
        b_waddr = tgt[BAW-1:0];
        b_wdata = b_rd;
        mv_rem_next = mv_rem - 1'b1;
        mv_off_next = mv_up ? mv_off + 1'b1 : mv_off - 1'b1;
        st_next = (mv_rem == LEN_W'(1)) ? S_MV_FIN : S_MV_RD;
      end

      S_MV_FIN: begin
        d_we = 1'b1;
        d_waddr = sa({1'b0, mv_slot});
        d_wdata = w_put(mv_to[POS_W-1:0], w_len(mv_word), w_nxt(mv_word));
        st_next = S_MV_RET;
      end

      S_MV_RET: begin
        case (ret)
          RET_PASS_UP: begin
            cur_next = cur + 10'd1;
            st_next = S_RS_P1_RD;
          end
          RET_PASS_DOWN: begin
            cur_next = cur - 10'd1;
            st_next = S_RS_P2_RD;
          end
          default: st_next = S_EQ_TAIL_RD;
        endcase
      end

      S_RS_START: begin
        rs_i_next = '0;
        rs_cum_next = '0;
        cur_next = 10'd1;
        st_next = S_RS_P1_RD;
      end

      // Upward pass: compute each live run's target and move the ones going down.
      S_RS_P1_RD: begin
        if (cur > {1'b0, hs}) begin
          cur_next = {1'b0, hs};
          st_next = S_RS_P2_RD;
        end else begin
          d_re = 1'b1;
          d_raddr = sa(cur);
          st_next = S_RS_P1_CK;
        end
      end

      S_RS_P1_CK: begin
        wn_next = d_rd;
        if (w_used(d_rd)) begin
          prod_next = {12'd0, rs_i} * {9'd0, free};
          st_next = S_RS_DIVGO;
        end else begin
          cur_next = cur + 10'd1;
          st_next = S_RS_P1_RD;
        end
      end

      S_RS_DIVGO: begin
        div_start = 1'b1;
        st_next = S_RS_DIVW;
      end

      S_RS_DIVW: begin
        if (div_done) begin
          tgt = rs_cum + div_quot[CNT_W-1:0];
          t_we = 1'b1;
          t_addr = sa(cur);
          t_wdata = tgt;
          rs_cum_next = rs_cum + {1'b0, w_len(wn)};
          rs_i_next = rs_i + 1'b1;
          if (tgt < {1'b0, w_pos(wn)}) begin
            mv_to_next = tgt;
            mv_slot_next = cur[SLOT_W-1:0];
            mv_word_next = wn;
            ret_next = RET_PASS_UP;
            st_next = S_MV_START;
          end else begin
            cur_next = cur + 10'd1;
            st_next = S_RS_P1_RD;
          end
        end
      end

      // Downward pass: move the runs whose target lies above them.
      S_RS_P2_RD: begin
        if (cur == '0) begin
          st_next = S_RS_END;
        end else begin
          d_re = 1'b1;
          d_raddr = sa(cur);
          t_re = 1'b1;
          t_addr = sa(cur);
          st_next = S_RS_P2_CK;
        end
      end

      S_RS_P2_CK: begin
        if (w_used(d_rd) && t_rd > {1'b0, w_pos(d_rd)}) begin
          mv_to_next = t_rd;
          mv_slot_next = cur[SLOT_W-1:0];
          mv_word_next = d_rd;
          ret_next = RET_PASS_DOWN;
          st_next = S_MV_START;
        end else begin
          cur_next = cur - 10'd1;
          st_next = S_RS_P2_RD;
        end
      end

      S_RS_END: begin
        st_next = (cmd == CMD_CREATE) ? S_DONE : S_EQ_TAIL_RD;
      end

      S_DONE: begin
        if (res_ok) begin
          emit = 1'b1;
          st_next = S_IDLE;
        end
      end

      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hs <= '0;
      live <= '0;
      region <= CNT_W'(BUFFER_BYTES);
      free <= CNT_W'(BUFFER_BYTES);
      holes <= '0;
    end else begin
      hs <= hs_next;
      live <= live_next;
      region <= region_next;
      free <= free_next;
      holes <= holes_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next; qid <= qid_next; din <= din_next;
    cur <= cur_next; prv <= prv_next; wq <= wq_next; wn <= wn_next; lim <= lim_next;
    newq <= newq_next; dout <= dout_next; status <= status_next; ret <= ret_next;
    mv_slot <= mv_slot_next; mv_word <= mv_word_next; mv_to <= mv_to_next;
    mv_off <= mv_off_next; mv_rem <= mv_rem_next; mv_up <= mv_up_next;
    rs_i <= rs_i_next; rs_cum <= rs_cum_next; prod <= prod_next;
  end

  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, live} + {1'b0, holes}) == {1'b0, hs})
    else $error("live and free slots do not add up to the slot count");

  a_free_le_region: assert property (@(posedge clk) disable iff (rst)
    free <= region)
    else $error("free byte count exceeds the data region");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    emit |=> st == S_IDLE)
    else $error("result word sent without returning to idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (d_we && d_re) |-> d_waddr != d_raddr)
    else $error("descriptor read and write hit the same entry");
endmodule

// ===== rtl/shared_buffer_byte_queues_top.sv =====
// Channel    Modport  Word fields
// request    sink     command[1:0], queue_id[8:0], data_in[7:0]
// response   source   new_queue[8:0], data_out[7:0], status[1:0]
//
// One command at a time; a new command is taken once the previous result word
// sits in the output register. Dequeue and enqueue each run through the
// descriptor memory read-modify-write sequence; create of a reused slot scans
// the slots one at a time. A neighbor shift or re-spread copies the data one
// byte at a time, and a re-spread runs the serial divider once per live queue.
// Reset is synchronous: descriptor entries above the highest slot are never
// read, so no clearing pass is run.
// A stalled response holds its word; the next command waits only for that slot.
module shared_buffer_byte_queues_top #(
  parameter int BUFFER_BYTES = sbq_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_QUEUES = sbq_pkg::MAX_QUEUES_DEF
) (
  input logic clk,
  input logic rst,
  sbq_in_if.sink    request,
  sbq_out_if.source response
);
  import sbq_pkg::*;

  req_t  req;
  resp_t resp;
  resp_t out_word;
  logic  out_valid;
  logic  idle, emit, res_ok;
  logic  div_start, div_done;
  logic [PROD_W-1:0] div_dividend, div_quot;
  logic [LIVE_W-1:0] div_divisor;

  assign req = '{cmd: cmd_t'(request.command), qid: request.queue_id,
                 din: request.data_in};
  assign request.ready = idle;
  assign res_ok = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_word <= resp;
  end

  assign response.valid = out_valid;
  assign response.new_queue = out_word.new_queue;
  assign response.data_out = out_word.data_out;
  assign response.status = out_word.status;

  sbq_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .MAX_QUEUES(MAX_QUEUES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(request.valid && idle),
    .req(req),
    .res_ok(res_ok),
    .idle(idle),
    .emit(emit),
    .resp(resp),
    .div_start(div_start),
    .div_dividend(div_dividend),
    .div_divisor(div_divisor),
    .div_done(div_done),
    .div_quot(div_quot)
  );

  sbq_div #(
    .DW(PROD_W),
    .VW(LIVE_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_dividend),
    .divisor(div_divisor),
    .done(div_done),
    .quot(div_quot)
  );
endmodule
